FILE: src/line_rasterizer_assert.svh
// ---------------------------------------------------------------------------
// line_rasterizer assertion macros
// Clocked implication checks used by the rasterizer RTL.
// ---------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lr_pkg.sv
// ---------------------------------------------------------------------------
// lr_pkg
// Types and constants shared by the line rasterizer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lr_pkg;

	localparam int COORD_W  = 12;          // coordinate width, two's complement
	localparam int COLOR_W  = 24;
	localparam int STEP_W   = COORD_W + 2; // 2*dx, 2*|dy| and their differences
	localparam int DT_W     = COORD_W + 4; // decision term and ALU width
	localparam int BURST    = 64;          // pixels per start beat
	localparam int BURST_W  = $clog2(BURST);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t              start_x;
		coord_t              start_y;
		coord_t              end_x;
		coord_t              end_y;
		logic [COLOR_W-1:0]  line_color;
	} seg_t;

	typedef struct packed {
		coord_t              pixel_x;
		coord_t              pixel_y;
		logic [COLOR_W-1:0]  pixel_color;
		logic                last_pixel;
	} pix_t;

	typedef enum logic [1:0] {
		MODE_SHALLOW_UP   = 2'd0,
		MODE_STEEP_UP     = 2'd1,
		MODE_STEEP_DOWN   = 2'd2, // also zero length
		MODE_SHALLOW_DOWN = 2'd3  // also horizontal
	} lr_mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DX,
		S_DY,
		S_ADY,
		S_CMP,
		S_INIT,
		S_KT,
		S_KP,
		S_RUN,
		S_HOLD
	} lr_state_t;

	typedef struct packed {
		logic sub;
	} alu_ctl_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} alu_flags_t;

endpackage

FILE: src/lr_alu.sv
// ---------------------------------------------------------------------------
// lr_alu
// Shared add/subtract unit with sign and zero flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lr_alu (
	input  logic signed [lr_pkg::DT_W-1:0] a,
	input  logic signed [lr_pkg::DT_W-1:0] b,
	input  lr_pkg::alu_ctl_t               ctl,
	output logic signed [lr_pkg::DT_W-1:0] sum,
	output lr_pkg::alu_flags_t             flags
);

	logic [lr_pkg::DT_W-1:0] b_eff;

	// a - b as a + ~b + 1
	assign b_eff      = ctl.sub ? ~b : b;
	assign sum        = a + b_eff + lr_pkg::DT_W'(ctl.sub);
	assign flags.neg  = sum[lr_pkg::DT_W-1];
	assign flags.zero = (sum == '0);

endmodule

FILE: src/line_rasterizer.sv
// ---------------------------------------------------------------------------
// line_rasterizer
// Bresenham line drawing: one segment in, its pixels out in x order.
// ---------------------------------------------------------------------------
// Usage:
//  - Command beat: seg is taken at a rising edge with start high and busy low.
//  - Result beats: pix is valid for exactly one cycle while pix_strobe is high;
//    the receiver cannot stall, so every strobe must be consumed.
//  - Setup runs on the shared adder: dx, dy, |dy|, octant compare, initial
//    decision term, two per-pixel increments; dx is redone when the endpoints
//    are swapped. Then one pixel per cycle within a burst, each presented in
//    the cycle after it is stepped. busy stays high until the final pixel of
//    a burst is stepped; the single decision-term add per cycle sets the rate.
//  - Segments longer than 64 pixels come out in bursts of 64: busy drops after
//    each burst and the next start beat only resumes the segment, its payload
//    is dropped. The last pixel of the segment carries last_pixel.
//  - Reset (arst_n low) returns to idle with no strobe; no clearing pass.
//  - A new command may be taken in the cycle the final pixel is presented.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_rasterizer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lr_pkg::seg_t  seg,
	output logic          busy,
	output logic          pix_strobe,
	output lr_pkg::pix_t  pix
);

`include "line_rasterizer_assert.svh"

	localparam int CW = lr_pkg::COORD_W;
	localparam int DW = lr_pkg::DT_W;
	localparam int SW = lr_pkg::STEP_W;

	// sequencer
	lr_pkg::lr_state_t state_q, state_d;
	logic [lr_pkg::BURST_W-1:0] cnt_q;

	// segment registers
	lr_pkg::coord_t sx_q, sy_q, ex_q, ey_q;
	logic [lr_pkg::COLOR_W-1:0] color_q;
	logic signed [CW:0]   dx_q, dy_q, ady_q;
	logic signed [SW-1:0] step_major_q, step_minor_q;
	logic signed [SW-1:0] inc_take_q, inc_plain_q;
	logic signed [DW-1:0] decision_q;
	lr_pkg::coord_t       stop_q, cur_x_q, cur_y_q;
	lr_pkg::lr_mode_t     mode_q;

	// output register
	lr_pkg::pix_t result_q;
	logic         strobe_q;

	// shared adder
	logic signed [DW-1:0] alu_a, alu_b, alu_sum;
	lr_pkg::alu_ctl_t     alu_ctl;
	lr_pkg::alu_flags_t   alu_flags;

	logic accept;
	logic even_mode, shallow_mode, take, run_last, dy_pos, dx_gt;
	lr_pkg::coord_t major_coord;

	lr_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.ctl   (alu_ctl),
		.sum   (alu_sum),
		.flags (alu_flags)
	);

	assign accept = start && !busy;

	// per-pixel decisions and octant compare flags
	always_comb begin
		even_mode    = (mode_q == lr_pkg::MODE_SHALLOW_UP) ||
		               (mode_q == lr_pkg::MODE_STEEP_DOWN);
		shallow_mode = (mode_q == lr_pkg::MODE_SHALLOW_UP) ||
		               (mode_q == lr_pkg::MODE_SHALLOW_DOWN);
		take         = even_mode ? (!decision_q[DW-1] && decision_q != '0)
		                         : decision_q[DW-1];
		major_coord  = shallow_mode ? cur_x_q : cur_y_q;
		run_last     = (major_coord == stop_q);
		dy_pos       = !dy_q[CW] && (dy_q != '0);
		dx_gt        = !alu_flags.neg && !alu_flags.zero;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lr_pkg::S_IDLE: if (start) state_d = lr_pkg::S_DX;
			lr_pkg::S_DX:   if (!alu_flags.neg) state_d = lr_pkg::S_DY;
			lr_pkg::S_DY:   state_d = lr_pkg::S_ADY;
			lr_pkg::S_ADY:  state_d = lr_pkg::S_CMP;
			lr_pkg::S_CMP:  state_d = lr_pkg::S_INIT;
			lr_pkg::S_INIT: state_d = lr_pkg::S_KT;
			lr_pkg::S_KT:   state_d = lr_pkg::S_KP;
			lr_pkg::S_KP:   state_d = lr_pkg::S_RUN;
			lr_pkg::S_RUN: begin
				if (run_last)
					state_d = lr_pkg::S_IDLE;
				else if (cnt_q == lr_pkg::BURST_W'(lr_pkg::BURST - 1))
					state_d = lr_pkg::S_HOLD;
			end
			lr_pkg::S_HOLD: if (start) state_d = lr_pkg::S_RUN;
			default:        state_d = lr_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs: busy and adder operands
	always_comb begin
		busy        = 1'b1;
		alu_a       = '0;
		alu_b       = '0;
		alu_ctl.sub = 1'b0;
		unique case (state_q)
			lr_pkg::S_IDLE, lr_pkg::S_HOLD: busy = 1'b0;
			lr_pkg::S_DX: begin
				alu_a       = DW'(ex_q);
				alu_b       = DW'(sx_q);
				alu_ctl.sub = 1'b1;
			end
			lr_pkg::S_DY: begin
				alu_a       = DW'(ey_q);
				alu_b       = DW'(sy_q);
				alu_ctl.sub = 1'b1;
			end
			lr_pkg::S_ADY: begin
				alu_b       = DW'(dy_q);
				alu_ctl.sub = dy_q[CW];
			end
			lr_pkg::S_CMP: begin
				alu_a       = DW'(dx_q);
				alu_b       = DW'(ady_q);
				alu_ctl.sub = 1'b1;
			end
			lr_pkg::S_INIT: begin
				alu_ctl.sub = 1'b1;
				unique case (mode_q)
					lr_pkg::MODE_SHALLOW_UP: begin
						alu_a = DW'(ady_q) <<< 1;
						alu_b = DW'(dx_q);
					end
					lr_pkg::MODE_SHALLOW_DOWN: begin
						alu_a = DW'(dx_q);
						alu_b = DW'(ady_q) <<< 1;
					end
					lr_pkg::MODE_STEEP_UP: begin
						alu_a = DW'(ady_q);
						alu_b = DW'(dx_q) <<< 1;
					end
					lr_pkg::MODE_STEEP_DOWN: begin
						alu_a = DW'(dx_q) <<< 1;
						alu_b = DW'(ady_q);
					end
					default: ;
				endcase
			end
			lr_pkg::S_KT: begin
				// net change when the minor axis steps too
				alu_a       = even_mode ? DW'(step_major_q) : DW'(step_minor_q);
				alu_b       = even_mode ? DW'(step_minor_q) : DW'(step_major_q);
				alu_ctl.sub = 1'b1;
			end
			lr_pkg::S_KP: begin
				alu_b       = DW'(step_major_q);
				alu_ctl.sub = !even_mode;
			end
			lr_pkg::S_RUN: begin
				alu_a = decision_q;
				alu_b = take ? DW'(inc_take_q) : DW'(inc_plain_q);
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lr_pkg::S_IDLE;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == lr_pkg::S_RUN);
			if (accept)
				cnt_q <= '0;
			else if (state_q == lr_pkg::S_RUN)
				cnt_q <= cnt_q + lr_pkg::BURST_W'(1);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && state_q == lr_pkg::S_IDLE) begin
			sx_q    <= seg.start_x;
			sy_q    <= seg.start_y;
			ex_q    <= seg.end_x;
			ey_q    <= seg.end_y;
			color_q <= seg.line_color;
		end

		unique case (state_q)
			lr_pkg::S_DX: begin
				if (alu_flags.neg) begin
					sx_q <= ex_q;
					ex_q <= sx_q;
					sy_q <= ey_q;
					ey_q <= sy_q;
				end else begin
					dx_q <= alu_sum[CW:0];
				end
			end
			lr_pkg::S_DY:  dy_q  <= alu_sum[CW:0];
			lr_pkg::S_ADY: ady_q <= alu_sum[CW:0];
			lr_pkg::S_CMP: begin
				if (dy_pos)
					mode_q <= dx_gt ? lr_pkg::MODE_SHALLOW_UP : lr_pkg::MODE_STEEP_UP;
				else
					mode_q <= dx_gt ? lr_pkg::MODE_SHALLOW_DOWN : lr_pkg::MODE_STEEP_DOWN;
				step_major_q <= dx_gt ? (SW'(ady_q) <<< 1) : (SW'(dx_q) <<< 1);
				step_minor_q <= dx_gt ? (SW'(dx_q) <<< 1) : (SW'(ady_q) <<< 1);
				stop_q       <= dx_gt ? ex_q : ey_q;
				cur_x_q      <= sx_q;
				cur_y_q      <= sy_q;
			end
			lr_pkg::S_INIT: decision_q  <= alu_sum;
			lr_pkg::S_KT:   inc_take_q  <= alu_sum[SW-1:0];
			lr_pkg::S_KP:   inc_plain_q <= alu_sum[SW-1:0];
			lr_pkg::S_RUN: begin
				result_q.pixel_x     <= cur_x_q;
				result_q.pixel_y     <= cur_y_q;
				result_q.pixel_color <= color_q;
				result_q.last_pixel  <= run_last;
				if (!run_last) begin
					decision_q <= alu_sum;
					unique case (mode_q)
						lr_pkg::MODE_SHALLOW_UP: begin
							cur_x_q <= cur_x_q + CW'(1);
							if (take) cur_y_q <= cur_y_q + CW'(1);
						end
						lr_pkg::MODE_SHALLOW_DOWN: begin
							cur_x_q <= cur_x_q + CW'(1);
							if (take) cur_y_q <= cur_y_q - CW'(1);
						end
						lr_pkg::MODE_STEEP_UP: begin
							cur_y_q <= cur_y_q + CW'(1);
							if (take) cur_x_q <= cur_x_q + CW'(1);
						end
						lr_pkg::MODE_STEEP_DOWN: begin
							cur_y_q <= cur_y_q - CW'(1);
							if (take) cur_x_q <= cur_x_q + CW'(1);
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign pix_strobe = strobe_q;
	assign pix        = result_q;

	// assertion helpers
	logic in_setup, burst_end, last_beat;
	assign in_setup  = (state_q == lr_pkg::S_DY) || (state_q == lr_pkg::S_ADY) ||
	                   (state_q == lr_pkg::S_CMP) || (state_q == lr_pkg::S_INIT);
	assign burst_end = (state_q == lr_pkg::S_RUN) && !run_last &&
	                   (cnt_q == lr_pkg::BURST_W'(lr_pkg::BURST - 1));
	assign last_beat = pix_strobe && pix.last_pixel;

	// every stepping cycle presents exactly one beat next cycle
	`LR_ASSERT_NEXT(a_run_strobes, clk, arst_n, state_q == lr_pkg::S_RUN, pix_strobe, "no beat")
	// the final pixel always leaves the sequencer idle
	`LR_ASSERT_SAME(a_last_idle, clk, arst_n, last_beat, state_q == lr_pkg::S_IDLE, "not idle")
	// a full burst without the final pixel parks in hold
	`LR_ASSERT_NEXT(a_burst_hold, clk, arst_n, burst_end, state_q == lr_pkg::S_HOLD, "no hold")
	// no beat appears in the dy, |dy|, compare and init setup steps
	`LR_ASSERT_SAME(a_setup_quiet, clk, arst_n, in_setup, !pix_strobe, "beat during setup")

endmodule

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for line_rasterizer. A scoreboard class predicts the
// Bresenham pixel stream for every command beat taken; a monitor compares
// each strobed pixel field by field, in order. Directed lines cover the
// octants, ties, swaps, burst edges and the coordinate range edges; random
// lines follow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class pixel_scoreboard;
	// predicted walker state
	lr_pkg::coord_t cur_x, cur_y, stop_coord;
	int decision, step_major, step_minor;
	lr_pkg::lr_mode_t mode;
	logic [lr_pkg::COLOR_W-1:0] color;
	bit seg_open;

	lr_pkg::pix_t expected_pixels[$];
	int mismatches, pixels_checked, beats, segments;
	int mode_count[4];

	function new();
		seg_open = 0;
		mismatches = 0;
		pixels_checked = 0;
		beats = 0;
		segments = 0;
		foreach (mode_count[i]) mode_count[i] = 0;
	endfunction

	function int pending();
		return expected_pixels.size();
	endfunction

	function void load_segment(lr_pkg::seg_t s);
		int sx, sy, ex, ey, dx, dy, ady, t;
		sx = $signed(s.start_x);
		sy = $signed(s.start_y);
		ex = $signed(s.end_x);
		ey = $signed(s.end_y);
		if (sx > ex) begin
			t = sx; sx = ex; ex = t;
			t = sy; sy = ey; ey = t;
		end
		dx = ex - sx;
		dy = ey - sy;
		ady = (dy < 0) ? -dy : dy;
		if (dy > 0)
			mode = (dx > dy) ? lr_pkg::MODE_SHALLOW_UP : lr_pkg::MODE_STEEP_UP;
		else
			mode = (dx > ady) ? lr_pkg::MODE_SHALLOW_DOWN : lr_pkg::MODE_STEEP_DOWN;
		if (mode == lr_pkg::MODE_SHALLOW_UP || mode == lr_pkg::MODE_SHALLOW_DOWN) begin
			step_major = 2 * ady;
			step_minor = 2 * dx;
			stop_coord = lr_pkg::coord_t'(ex);
			decision = (mode == lr_pkg::MODE_SHALLOW_UP) ? 2 * ady - dx : dx - 2 * ady;
		end else begin
			step_major = 2 * dx;
			step_minor = 2 * ady;
			stop_coord = lr_pkg::coord_t'(ey);
			decision = (mode == lr_pkg::MODE_STEEP_UP) ? ady - 2 * dx : 2 * dx - ady;
		end
		cur_x = lr_pkg::coord_t'(sx);
		cur_y = lr_pkg::coord_t'(sy);
		color = s.line_color;
		seg_open = 1;
		mode_count[mode]++;
	endfunction

	function void advance();
		bit even, take_minor;
		even = !mode[0];
		take_minor = even ? (decision > 0) : (decision < 0);
		if (take_minor) begin
			decision += even ? -step_minor : step_minor;
			case (mode)
				lr_pkg::MODE_SHALLOW_UP:   cur_y = cur_y + lr_pkg::coord_t'(1);
				lr_pkg::MODE_SHALLOW_DOWN: cur_y = cur_y - lr_pkg::coord_t'(1);
				default:                   cur_x = cur_x + lr_pkg::coord_t'(1);
			endcase
		end
		decision += even ? step_major : -step_major;
		case (mode)
			lr_pkg::MODE_STEEP_UP:   cur_y = cur_y + lr_pkg::coord_t'(1);
			lr_pkg::MODE_STEEP_DOWN: cur_y = cur_y - lr_pkg::coord_t'(1);
			default:                 cur_x = cur_x + lr_pkg::coord_t'(1);
		endcase
	endfunction

	// one command beat: latch a new line if idle, then up to one burst of pixels
	function void note_beat(lr_pkg::seg_t s);
		int n, major;
		bit last;
		lr_pkg::pix_t p;
		beats++;
		if (!seg_open) begin
			segments++;
			load_segment(s);
		end
		n = 0;
		while (seg_open && n < lr_pkg::BURST) begin
			if (mode == lr_pkg::MODE_SHALLOW_UP || mode == lr_pkg::MODE_SHALLOW_DOWN)
				major = cur_x;
			else
				major = cur_y;
			last = (major == int'(stop_coord));
			p.pixel_x = cur_x;
			p.pixel_y = cur_y;
			p.pixel_color = color;
			p.last_pixel = last;
			expected_pixels.push_back(p);
			n++;
			if (last)
				seg_open = 0;
			else
				advance();
		end
	endfunction

	function void check_pixel(lr_pkg::pix_t got);
		lr_pkg::pix_t want;
		if (expected_pixels.size() == 0) begin
			$error("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y);
			mismatches++;
			return;
		end
		want = expected_pixels.pop_front();
		pixels_checked++;
		if (got.pixel_x !== want.pixel_x) begin
			$error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
			mismatches++;
		end
		if (got.pixel_y !== want.pixel_y) begin
			$error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
			mismatches++;
		end
		if (got.pixel_color !== want.pixel_color) begin
			$error("pixel_color: expected %06h, got %06h", want.pixel_color, got.pixel_color);
			mismatches++;
		end
		if (got.last_pixel !== want.last_pixel) begin
			$error("last_pixel: expected %0b, got %0b", want.last_pixel, got.last_pixel);
			mismatches++;
		end
	endfunction
endclass

module testbench;

	// Slowest correct run: about 330 command beats, each with up to 64 pixels,
	// an idle gap and, for a new line, setup. The limit is several times over.
	localparam int CYCLE_LIMIT   = 200_000;
	localparam int RANDOM_LINES  = 160;
	localparam int DRAIN_CYCLES  = 20;   // setup plus one pixel, with margin

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	lr_pkg::seg_t seg = '0;
	logic busy;
	logic pix_strobe;
	lr_pkg::pix_t pix;

	pixel_scoreboard sb;
	int cycle_count = 0;
	bit steady = 0;   // no idle gaps between beats while set

	always #5 clk = ~clk;

	line_rasterizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.seg        (seg),
		.busy       (busy),
		.pix_strobe (pix_strobe),
		.pix        (pix)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// pixel monitor: the receiver never stalls, so every strobe is a result beat
	always @(posedge clk) begin
		if (arst_n && pix_strobe)
			sb.check_pixel(pix);
	end

	function automatic lr_pkg::coord_t clamp_coord(int v);
		if (v < -2048) return lr_pkg::coord_t'(-2048);
		if (v > 2047) return lr_pkg::coord_t'(2047);
		return lr_pkg::coord_t'(v);
	endfunction

	function automatic lr_pkg::seg_t line_to(int sx, int sy, int ex, int ey, logic [23:0] c);
		lr_pkg::seg_t s;
		s.start_x = clamp_coord(sx);
		s.start_y = clamp_coord(sy);
		s.end_x = clamp_coord(ex);
		s.end_y = clamp_coord(ey);
		s.line_color = c;
		return s;
	endfunction

	// payload for resume beats; the block must drop it
	function automatic lr_pkg::seg_t random_payload();
		lr_pkg::seg_t s;
		s.start_x = lr_pkg::coord_t'($urandom);
		s.start_y = lr_pkg::coord_t'($urandom);
		s.end_x = lr_pkg::coord_t'($urandom);
		s.end_y = lr_pkg::coord_t'($urandom);
		s.line_color = 24'($urandom);
		return s;
	endfunction

	// mostly short lines anywhere in the plane, a few long ones and special shapes
	function automatic lr_pkg::seg_t random_line();
		int kind, span, sx, sy, ex, ey, len;
		logic [23:0] c;
		kind = $urandom_range(0, 99);
		sx = $urandom_range(0, 4095) - 2048;
		sy = $urandom_range(0, 4095) - 2048;
		c = 24'($urandom);
		if ($urandom_range(0, 15) == 0)
			c = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
		if (kind < 92) begin
			if (kind < 75)
				span = 24;
			else if (kind < 90)
				span = 200;
			else
				span = 600;
			ex = sx + $urandom_range(0, 2 * span) - span;
			ey = sy + $urandom_range(0, 2 * span) - span;
		end else begin
			len = $urandom_range(0, 120) - 60;
			case ($urandom_range(0, 3))
				0: begin ex = sx;       ey = sy;       end  // single pixel
				1: begin ex = sx + len; ey = sy;       end  // horizontal
				2: begin ex = sx;       ey = sy + len; end  // vertical
				default: begin                               // diagonal
					ex = sx + len;
					ey = $urandom_range(0, 1) ? sy + len : sy - len;
				end
			endcase
		end
		return line_to(sx, sy, ex, ey, c);
	endfunction

	// one command beat; waits for busy low, then an optional idle gap
	task automatic issue_beat(lr_pkg::seg_t s);
		int gap;
		start <= 1'b1;
		seg <= s;
		do @(posedge clk); while (busy);
		sb.note_beat(s);
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// first beat latches the line, resume beats carry junk until it is done
	task automatic send_segment(lr_pkg::seg_t s);
		issue_beat(s);
		while (sb.seg_open)
			issue_beat(random_payload());
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed lines ----
		send_segment(line_to(0, 0, 0, 0, 24'h000000));                 // single pixel
		send_segment(line_to(-2048, -2048, -2048, -2048, 24'hFFFFFF));
		send_segment(line_to(2047, 2047, 2047, 2047, 24'hA5A5A5));
		send_segment(line_to(-5, 3, 10, 3, 24'h123456));               // horizontal
		send_segment(line_to(10, -3, -5, -3, 24'h5A5A5A));             // horizontal, swapped
		send_segment(line_to(7, -4, 7, 9, 24'hFF0000));                // vertical up
		send_segment(line_to(7, 9, 7, -4, 24'h00FF00));                // vertical down
		send_segment(line_to(0, 0, 12, 12, 24'h0000FF));               // 45 degrees up
		send_segment(line_to(0, 0, 12, -12, 24'hFFFF00));              // 45 degrees down
		send_segment(line_to(0, 0, 20, 7, 24'h00FFFF));                // shallow up
		send_segment(line_to(0, 0, 7, 20, 24'hFF00FF));                // steep up
		send_segment(line_to(0, 0, 20, -7, 24'h808080));               // shallow down
		send_segment(line_to(0, 0, 7, -20, 24'h7F7F7F));               // steep down
		send_segment(line_to(20, 7, 0, 0, 24'h010203));                // shallow up, swapped
		send_segment(line_to(7, -20, 0, 0, 24'hFEFDFC));               // steep down, swapped
		// decision term exactly zero at the first step in each mode
		send_segment(line_to(0, 0, 2, 1, 24'h111111));
		send_segment(line_to(0, 0, 1, 2, 24'h222222));
		send_segment(line_to(0, 0, 1, -2, 24'h333333));
		send_segment(line_to(0, 0, 2, -1, 24'h444444));
		// burst boundary: exactly one burst, then one pixel over
		send_segment(line_to(-100, 5, -37, 5, 24'hC0FFEE));
		send_segment(line_to(0, 0, 64, 30, 24'hBADA55));
		// full-range diagonal, then shorter lines along the range edges
		send_segment(line_to(-2048, -2048, 2047, 2047, 24'hFFFFFF));
		send_segment(line_to(2047, -2048, 1900, -2048, 24'h000000));   // bottom edge, swapped
		send_segment(line_to(-2048, 2047, -2048, 1900, 24'hF0F0F0));   // left edge, down
		send_segment(line_to(1847, 2047, 2047, 1950, 24'h0F0F0F));     // shallow down, top edge to right edge
		wait_drain();   // hold off until every pixel so far has come out

		// ---- random lines ----
		for (int i = 0; i < RANDOM_LINES; i++) begin
			steady = ((i / 40) % 4 == 3);
			send_segment(random_line());
			if (i % 50 == 49)
				wait_drain();
		end

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected pixels never came out", sb.pending());
			sb.mismatches++;
		end

		$display("Drew %0d lines over %0d command beats, %0d pixels checked.",
			sb.segments, sb.beats, sb.pixels_checked);
		$display("Lines per octant: shallow up %0d, steep up %0d, steep down %0d, shallow down %0d.",
			sb.mode_count[lr_pkg::MODE_SHALLOW_UP], sb.mode_count[lr_pkg::MODE_STEEP_UP],
			sb.mode_count[lr_pkg::MODE_STEEP_DOWN], sb.mode_count[lr_pkg::MODE_SHALLOW_DOWN]);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
